// File: sv/chd_pkg.sv
// Shared types, constants and helpers for the chunked body decoder.
`timescale 1ns / 1ps
`default_nettype none

package chd_pkg;

  localparam int LINE_BUF   = 32;
  localparam int LINE_CNT_W = $clog2(LINE_BUF);
  localparam int LEN_WIDTH  = 24;
  localparam int MAX_W      = 24;
  localparam int TOTAL_W    = 24;
  localparam int SUM_W      = ((LEN_WIDTH > MAX_W) ? LEN_WIDTH : MAX_W) + 2;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 3;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = 1;
  localparam int Q_CNT_W    = 2;

  localparam logic [MAX_W-1:0] MAX_BODY_RST = MAX_W'(65536);
  localparam logic             REG_MAX_BODY = 1'b0;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_VT  = 8'h0B;
  localparam logic [7:0] CHAR_FF  = 8'h0C;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_SP  = 8'h20;

  typedef enum logic [2:0] {
    PH_LINE,
    PH_DATA,
    PH_SKIP1,
    PH_SKIP2,
    PH_DONE,
    PH_ERR
  } phase_t;

  typedef enum logic [1:0] {
    HX_LEAD,
    HX_DIGITS,
    HX_STOP
  } hex_st_t;

  typedef enum logic [1:0] {
    K_BYTE,
    K_DONE,
    K_STREAM,
    K_OVER
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_beat_t;

  typedef struct packed {
    kind_t              out_kind;
    logic [7:0]         out_byte;
    logic [TOTAL_W-1:0] total_len;
  } out_beat_t;

  // Classified input beat handed from front to back.
  typedef struct packed {
    logic [7:0] byte_v;
    logic       stream_end;
    logic       is_lf;
    logic       is_cr;
    logic       is_blank;
    logic       is_hex;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t tok;
  } tok_if_t;

  function automatic token_t classify(input in_beat_t b);
    token_t     t;
    logic [7:0] c;
    c            = b.in_byte;
    t.byte_v     = c;
    t.stream_end = b.stream_end;
    t.is_lf      = (c == CHAR_LF);
    t.is_cr      = (c == CHAR_CR);
    t.is_blank   = (c == CHAR_SP) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    t.is_hex     = 1'b1;
    t.digit      = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      t.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      t.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      t.digit = 4'(c - 8'h37);
    end else begin
      t.is_hex = 1'b0;
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: sv/chd_front.sv
// Front end: accepts input beats, classifies each byte and queues the tokens.
`timescale 1ns / 1ps
`default_nettype none

module chd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire chd_pkg::in_beat_t in_data,
  output chd_pkg::tok_if_t      tok_o,
  input  wire logic             tok_pop
);
  import chd_pkg::*;

  token_t             q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = tok_pop && (cnt_r != '0);

  assign tok_o.valid = (cnt_r != '0);
  assign tok_o.tok   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= classify(in_data);
    end
  end

endmodule

`default_nettype wire

// File: sv/chd_back.sv
// Back end: framing state machine over classified tokens plus the result queue.
`timescale 1ns / 1ps
`default_nettype none

module chd_back (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire chd_pkg::tok_if_t          tok_i,
  output logic                           tok_pop,
  input  wire logic [chd_pkg::MAX_W-1:0] max_body,
  output logic                           empty,
  input  wire logic                      pop,
  output chd_pkg::out_beat_t             out_data
);
  import chd_pkg::*;

  localparam logic [LEN_WIDTH:0] ACC_SAT = {1'b1, {LEN_WIDTH{1'b0}}};

  phase_t                phase_r, phase_nxt;
  hex_st_t               hx_r, hx_nxt, hx_tk;
  logic [LINE_CNT_W-1:0] lc_r, lc_nxt, lc_inc;
  logic [LEN_WIDTH:0]    acc_r, acc_nxt, acc_tk, size_fin;
  logic [LEN_WIDTH-1:0]  left_r, left_nxt, left_dec;
  logic [LEN_WIDTH-1:0]  total_r, total_nxt;
  logic [SUM_W-1:0]      need;
  logic                  adv, active, finish, emit;
  kind_t                 kind;
  logic [7:0]            obyte;
  token_t                tok;

  out_beat_t          q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               room, do_pop;

  assign tok     = tok_i.tok;
  assign do_pop  = pop && (cnt_r != '0);
  assign room    = (cnt_r != Q_CNT_W'(Q_DEPTH)) || do_pop;
  assign adv     = tok_i.valid && room;
  assign tok_pop = adv;
  assign active  = (phase_r == PH_LINE) || (phase_r == PH_DATA) ||
                   (phase_r == PH_SKIP1) || (phase_r == PH_SKIP2);

  // Fold one size-line character into the hex accumulator.
  always_comb begin
    hx_tk  = hx_r;
    acc_tk = acc_r;
    if (!(hx_r == HX_LEAD && tok.is_blank) && (hx_r == HX_LEAD || hx_r == HX_DIGITS)) begin
      if (!tok.is_hex) begin
        hx_tk = HX_STOP;
      end else begin
        hx_tk = HX_DIGITS;
        if (!acc_r[LEN_WIDTH]) begin
          if (acc_r[LEN_WIDTH-1 -: 4] != 4'd0) begin
            acc_tk = ACC_SAT;
          end else begin
            acc_tk = {1'b0, acc_r[LEN_WIDTH-5:0], tok.digit};
          end
        end
      end
    end
  end

  always_comb begin
    lc_inc   = lc_r + 1'b1;
    size_fin = tok.is_lf ? acc_r : acc_tk;
    need     = SUM_W'(total_r) + SUM_W'(size_fin[LEN_WIDTH-1:0]) + SUM_W'(1);
    left_dec = (left_r != '0) ? left_r - 1'b1 : left_r;
  end

  always_comb begin
    phase_nxt = phase_r;
    hx_nxt    = hx_r;
    lc_nxt    = lc_r;
    acc_nxt   = acc_r;
    left_nxt  = left_r;
    total_nxt = total_r;
    emit      = 1'b0;
    kind      = K_BYTE;
    obyte     = 8'd0;
    finish    = 1'b0;
    if (adv && active) begin
      if (tok.stream_end) begin
        phase_nxt = PH_ERR;
        emit      = 1'b1;
        kind      = K_STREAM;
      end else begin
        case (phase_r)
          PH_LINE: begin
            if (tok.is_lf) begin
              finish = 1'b1;
            end else if (!tok.is_cr) begin
              hx_nxt  = hx_tk;
              acc_nxt = acc_tk;
              if (lc_inc == LINE_CNT_W'(LINE_BUF - 1)) begin
                finish = 1'b1;
              end else begin
                lc_nxt = lc_inc;
              end
            end
          end
          PH_DATA: begin
            total_nxt = total_r + 1'b1;
            left_nxt  = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_SKIP1;
            end
            emit  = 1'b1;
            kind  = K_BYTE;
            obyte = tok.byte_v;
          end
          PH_SKIP1: begin
            phase_nxt = PH_SKIP2;
          end
          PH_SKIP2: begin
            phase_nxt = PH_LINE;
          end
          default: begin
          end
        endcase
        if (finish) begin
          lc_nxt  = '0;
          hx_nxt  = HX_LEAD;
          acc_nxt = '0;
          if (size_fin == '0) begin
            phase_nxt = PH_DONE;
            emit      = 1'b1;
            kind      = K_DONE;
          end else if (size_fin[LEN_WIDTH] || (need > SUM_W'(max_body))) begin
            phase_nxt = PH_ERR;
            emit      = 1'b1;
            kind      = K_OVER;
          end else begin
            left_nxt  = size_fin[LEN_WIDTH-1:0];
            phase_nxt = PH_DATA;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LINE;
      hx_r    <= HX_LEAD;
      lc_r    <= '0;
      acc_r   <= '0;
      left_r  <= '0;
      total_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      hx_r    <= hx_nxt;
      lc_r    <= lc_nxt;
      acc_r   <= acc_nxt;
      left_r  <= left_nxt;
      total_r <= total_nxt;
    end
  end

  // Result queue.
  assign empty    = (cnt_r == '0);
  assign out_data = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (emit && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !emit) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (emit) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      q_r[wr_ptr_r] <= '{out_kind: kind, out_byte: obyte, total_len: TOTAL_W'(total_nxt)};
    end
  end

endmodule

`default_nettype wire

// File: sv/http_chunked_body_decoder_core.sv
// Top level of the chunked body decoder: front, back and the register port.
// Path: a beat taken on push is registered in the front token queue, then
//   any result it yields is registered in the back result queue for pop.
// Throughput: one input beat per cycle unless the result queue stays full; each
//   beat is one back-end state update; two-entry queues decouple both sides.
// Reset: synchronous, active low; queues empty, decoder in the size line phase,
//   max_body back to 65536.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        push,
  output logic                             full,
  input  wire chd_pkg::in_beat_t           in_data,
  // result channel
  output logic                             empty,
  input  wire logic                        pop,
  output chd_pkg::out_beat_t               out_data,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [chd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [chd_pkg::DATA_W-1:0]  pwdata,
  output logic [chd_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import chd_pkg::*;

  logic [MAX_W-1:0] max_body_r, max_body_nxt;
  logic             reg_sel;
  logic             wr_en;
  tok_if_t          tok;
  logic             tok_pop;

  // Register map: one 24-bit register, max_body, read zero-extended to 32 bits, at byte address zero.
  // Address bit 2 picks the register slot; low bits are ignored.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_MAX_BODY);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    max_body_nxt = max_body_r;
    if (wr_en && reg_sel) begin
      max_body_nxt = pwdata[MAX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAX_BODY_RST;
    end else begin
      max_body_r <= max_body_nxt;
    end
  end

  // Read back the register; unmapped slots read as zero.
  assign prdata = reg_sel ? DATA_W'(max_body_r) : '0;

  // Front: take a beat whenever the token queue has room and tag the byte
  // (line feed, carriage return, blank, hex digit value).
  chd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .tok_o   (tok),
    .tok_pop (tok_pop)
  );

  // Back: advance the framing state machine one token per cycle while the
  // result queue can take a beat; drop tokens once done or in error.
  chd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok_i    (tok),
    .tok_pop  (tok_pop),
    .max_body (max_body_r),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
